### rtl/ocm_pkg.sv
// Shared types and constants for the oxygen cell calibration and depth block.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ocm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int O2_W        = 10;
    localparam int DEPTH_W     = 15;
    localparam int ACC_W       = 20;
    // positive reference fits below the sign bit of the accumulator
    localparam int REF_W       = ACC_W - 1;
    // product of air fraction and a positive sample
    localparam int PROD_W      = CFG_W + SAMPLE_W - 1;

    localparam logic OP_MEAS = 1'b0;
    localparam logic OP_CAL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AIR_O2       = 2'd0,
        REG_LIMIT_NORMAL = 2'd1,
        REG_LIMIT_TECH   = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] AIR_O2_RESET       = 8'd209;
    localparam logic [CFG_W-1:0] LIMIT_NORMAL_RESET = 8'd140;
    localparam logic [CFG_W-1:0] LIMIT_TECH_RESET   = 8'd160;

    localparam int O2_MIN       = 10;
    localparam int O2_MAX       = 1000;
    localparam int MOD_SCALE    = 1000;
    localparam int DEPTH_OFFSET = 100;
    localparam int DEPTH_MAX    = 32767;

endpackage

`default_nettype wire

### rtl/ocm_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; instantiated twice by oxygen_cell_calibrate_and_mod.
`timescale 1ns / 1ps
`default_nettype none

module ocm_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] qn_reg, qn_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, qn_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qn_next   = qn_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            qn_next   = numer;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            // numerator shifts out at the top, quotient bits shift in below
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            qn_next  = {qn_reg[NUM_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = qn_reg;

endmodule

`default_nettype wire

### rtl/oxygen_cell_calibrate_and_mod.sv
// Oxygen cell calibration, O2 scaling and maximum operating depth.
// Calibration word: result loaded into the output register once it is free, then ready for the next word.
// Measurement word: a shift-add multiply over the bits of the air fraction plus two NUM_W-step serial
// divisions (O2, then both depths in parallel), then S_OUT, which waits for the output
// register to be free before the block is ready for the next word; without a reference or
// with a non-positive sample only the depth division runs.
// Reset: limits and air fraction to defaults, calibration sum cleared, not calibrated.
`timescale 1ns / 1ps
`default_nettype none

module oxygen_cell_calibrate_and_mod #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic signed [ocm_pkg::SAMPLE_W-1:0]   sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ocm_pkg::O2_W-1:0]              o2_tenths,
    output logic [ocm_pkg::DEPTH_W-1:0]           depth_normal_tenths,
    output logic [ocm_pkg::DEPTH_W-1:0]           depth_tech_tenths,
    output logic                                  calibration_done,
    output logic                                  not_calibrated,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ocm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ocm_pkg::CFG_W-1:0]             cfg_data
);

    import ocm_pkg::*;

    localparam int CNT_W   = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int NUM_W   = PROD_W + $clog2(CAL_SAMPLES + 1);
    localparam int MCNT_W  = $clog2(CFG_W);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_DIV_O2 = 5'b00100,
        S_DEPTH  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    function automatic logic [DEPTH_W-1:0] depth_of(input logic [NUM_W-1:0] q);
        logic [NUM_W-1:0] d;
        d = q - NUM_W'(DEPTH_OFFSET);
        if (q < NUM_W'(DEPTH_OFFSET))
            return '0;
        else if (d > NUM_W'(DEPTH_MAX))
            return DEPTH_W'(DEPTH_MAX);
        else
            return d[DEPTH_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CFG_W-1:0] air_reg, limit_n_reg, limit_t_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REF_W-1:0] ref_reg, ref_next;
    logic             ref_valid_reg, ref_valid_next;
    logic             start_a_reg, start_a_next;
    logic             start_b_reg, start_b_next;
    logic             out_valid_reg, out_valid_next;

    logic [CFG_W-1:0]  mul_a_reg, mul_a_next;
    logic [PROD_W-1:0] mul_b_reg, mul_b_next;
    logic [PROD_W-1:0] mul_acc_reg, mul_acc_next;
    logic [MCNT_W-1:0] mul_cnt_reg, mul_cnt_next;

    logic [O2_W-1:0]    o2_reg, o2_next;
    logic [DEPTH_W-1:0] dn_reg, dn_next;
    logic [DEPTH_W-1:0] dt_reg, dt_next;
    logic               done_reg, done_next;
    logic               nc_reg, nc_next;

    logic [O2_W-1:0]    o2_out_reg, o2_out_next;
    logic [DEPTH_W-1:0] dn_out_reg, dn_out_next;
    logic [DEPTH_W-1:0] dt_out_reg, dt_out_next;
    logic               done_out_reg, done_out_next;
    logic               nc_out_reg, nc_out_next;

    logic [ACC_W-1:0] acc_sum;
    logic             acc_pos;
    logic [NUM_W-1:0] numer_a, numer_b;
    logic [REF_W-1:0] denom_a, denom_b;
    logic [NUM_W-1:0] quot_a, quot_b;
    logic             done_a, done_b;

    assign acc_sum = acc_reg + {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign acc_pos = !acc_sum[ACC_W-1] && (acc_sum != '0);

    // divider A does the O2 scaling first, then the first depth
    assign numer_a = (state_reg == S_DIV_O2)
                   ? NUM_W'(mul_acc_reg) * NUM_W'(CAL_SAMPLES)
                   : NUM_W'(limit_n_reg) * NUM_W'(MOD_SCALE);
    assign denom_a = (state_reg == S_DIV_O2) ? ref_reg : REF_W'(o2_reg);
    assign numer_b = NUM_W'(limit_t_reg) * NUM_W'(MOD_SCALE);
    assign denom_b = REF_W'(o2_reg);

    ocm_div #(.NUM_W(NUM_W), .DEN_W(REF_W)) u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_a_reg),
        .numer (numer_a),
        .denom (denom_a),
        .done  (done_a),
        .quot  (quot_a)
    );

    ocm_div #(.NUM_W(NUM_W), .DEN_W(REF_W)) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_b_reg),
        .numer (numer_b),
        .denom (denom_b),
        .done  (done_b),
        .quot  (quot_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ref_next       = ref_reg;
        ref_valid_next = ref_valid_reg;
        start_a_next   = 1'b0;
        start_b_next   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_acc_next   = mul_acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        o2_next        = o2_reg;
        dn_next        = dn_reg;
        dt_next        = dt_reg;
        done_next      = done_reg;
        nc_next        = nc_reg;
        o2_out_next    = o2_out_reg;
        dn_out_next    = dn_out_reg;
        dt_out_next    = dt_out_reg;
        done_out_next  = done_out_reg;
        nc_out_next    = nc_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_CAL)
                    begin
                        acc_next  = acc_sum;
                        cnt_next  = cnt_reg + 1'b1;
                        done_next = 1'b0;
                        nc_next   = !ref_valid_reg;
                        if (cnt_reg == CNT_W'(CAL_SAMPLES - 1))
                        begin
                            // sum complete: take it as reference, drop it if not positive
                            ref_next       = acc_sum[REF_W-1:0];
                            ref_valid_next = acc_pos;
                            acc_next       = '0;
                            cnt_next       = '0;
                            done_next      = 1'b1;
                            nc_next        = !acc_pos;
                        end
                        o2_next    = '0;
                        dn_next    = '0;
                        dt_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        done_next = 1'b0;
                        nc_next   = !ref_valid_reg;
                        if (!ref_valid_reg)
                        begin
                            o2_next      = O2_W'(O2_MAX);
                            start_a_next = 1'b1;
                            start_b_next = 1'b1;
                            state_next   = S_DEPTH;
                        end
                        else if (sample[SAMPLE_W-1] || (sample == '0))
                        begin
                            o2_next      = O2_W'(O2_MIN);
                            start_a_next = 1'b1;
                            start_b_next = 1'b1;
                            state_next   = S_DEPTH;
                        end
                        else
                        begin
                            mul_a_next   = air_reg;
                            mul_b_next   = PROD_W'(sample[SAMPLE_W-2:0]);
                            mul_acc_next = '0;
                            mul_cnt_next = '0;
                            state_next   = S_MUL;
                        end
                    end
                end
            end

            S_MUL:
            begin
                // one bit of the air fraction per cycle
                if (mul_a_reg[0])
                    mul_acc_next = mul_acc_reg + mul_b_reg;
                mul_a_next   = mul_a_reg >> 1;
                mul_b_next   = mul_b_reg << 1;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == '1)
                begin
                    start_a_next = 1'b1;
                    state_next   = S_DIV_O2;
                end
            end

            S_DIV_O2:
            begin
                if (done_a)
                begin
                    if (quot_a > NUM_W'(O2_MAX))
                        o2_next = O2_W'(O2_MAX);
                    else if (quot_a < NUM_W'(O2_MIN))
                        o2_next = O2_W'(O2_MIN);
                    else
                        o2_next = quot_a[O2_W-1:0];
                    start_a_next = 1'b1;
                    start_b_next = 1'b1;
                    state_next   = S_DEPTH;
                end
            end

            S_DEPTH:
            begin
                if (done_a && done_b)
                begin
                    dn_next    = depth_of(quot_a);
                    dt_next    = depth_of(quot_b);
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o2_out_next    = o2_reg;
                    dn_out_next    = dn_reg;
                    dt_out_next    = dt_reg;
                    done_out_next  = done_reg;
                    nc_out_next    = nc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            air_reg       <= AIR_O2_RESET;
            limit_n_reg   <= LIMIT_NORMAL_RESET;
            limit_t_reg   <= LIMIT_TECH_RESET;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            ref_reg       <= '0;
            ref_valid_reg <= 1'b0;
            start_a_reg   <= 1'b0;
            start_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            ref_reg       <= ref_next;
            ref_valid_reg <= ref_valid_next;
            start_a_reg   <= start_a_next;
            start_b_reg   <= start_b_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_AIR_O2:       air_reg     <= cfg_data;
                    REG_LIMIT_NORMAL: limit_n_reg <= cfg_data;
                    REG_LIMIT_TECH:   limit_t_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_acc_reg  <= mul_acc_next;
        mul_cnt_reg  <= mul_cnt_next;
        o2_reg       <= o2_next;
        dn_reg       <= dn_next;
        dt_reg       <= dt_next;
        done_reg     <= done_next;
        nc_reg       <= nc_next;
        o2_out_reg   <= o2_out_next;
        dn_out_reg   <= dn_out_next;
        dt_out_reg   <= dt_out_next;
        done_out_reg <= done_out_next;
        nc_out_reg   <= nc_out_next;
    end

    assign in_stall            = (state_reg != S_IDLE);
    assign cfg_ready           = 1'b1;
    assign out_valid           = out_valid_reg;
    assign o2_tenths           = o2_out_reg;
    assign depth_normal_tenths = dn_out_reg;
    assign depth_tech_tenths   = dt_out_reg;
    assign calibration_done    = done_out_reg;
    assign not_calibrated      = nc_out_reg;

endmodule

`default_nettype wire

### rtl/ocm_chk.sv
// Port-level checks on the result channel of oxygen_cell_calibrate_and_mod.
// Uses ocm_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module ocm_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ocm_pkg::O2_W-1:0]      o2_tenths,
    input logic [ocm_pkg::DEPTH_W-1:0]   depth_normal_tenths,
    input logic [ocm_pkg::DEPTH_W-1:0]   depth_tech_tenths,
    input logic                          calibration_done,
    input logic                          not_calibrated
);

    import ocm_pkg::*;

    // a stalled word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(o2_tenths)
            && $stable(depth_normal_tenths) && $stable(depth_tech_tenths))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> o2_tenths <= O2_W'(O2_MAX))
        else $error("O2 above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibration_done |-> o2_tenths == '0
            && depth_normal_tenths == '0 && depth_tech_tenths == '0)
        else $error("calibration word carries measurement data");

    // without a reference a measurement saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_calibrated |-> o2_tenths == O2_W'(O2_MAX) || o2_tenths == '0)
        else $error("uncalibrated measurement not saturated");

endmodule

bind oxygen_cell_calibrate_and_mod ocm_chk u_ocm_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .o2_tenths           (o2_tenths),
    .depth_normal_tenths (depth_normal_tenths),
    .depth_tech_tenths   (depth_tech_tenths),
    .calibration_done    (calibration_done),
    .not_calibrated      (not_calibrated)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for oxygen_cell_calibrate_and_mod: directed and random words
// with idling on both sides. Needs ocm_pkg and the top level from rtl.
`timescale 1ns / 1ps

module testbench;

    import ocm_pkg::*;

    localparam int CAL_COUNT    = 10;
    localparam int SETTLE_CYCLES = 100;
    localparam int ADC_MAX      = 32767;

    typedef struct packed {
        logic [O2_W-1:0]    o2;
        logic [DEPTH_W-1:0] depth_normal;
        logic [DEPTH_W-1:0] depth_tech;
        logic               cal_done;
        logic               no_ref;
    } reading_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       opcode    = OP_MEAS;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data  = '0;

    logic                       in_stall;
    logic                       out_valid;
    logic [O2_W-1:0]            o2_tenths;
    logic [DEPTH_W-1:0]         depth_normal_tenths;
    logic [DEPTH_W-1:0]         depth_tech_tenths;
    logic                       calibration_done;
    logic                       not_calibrated;
    logic                       cfg_ready;

    // mirror of the block's registers and calibration state
    logic [CFG_W-1:0]           air_cfg        = AIR_O2_RESET;
    logic [CFG_W-1:0]           lim_normal_cfg = LIMIT_NORMAL_RESET;
    logic [CFG_W-1:0]           lim_tech_cfg   = LIMIT_TECH_RESET;
    logic signed [ACC_W-1:0]    cal_sum        = '0;
    logic signed [ACC_W-1:0]    ref_sum        = '0;
    int                         cal_taken      = 0;
    bit                         ref_ok         = 1'b0;

    reading_t                   pending_readings[$];
    int                         err_count      = 0;
    int                         words_sent     = 0;
    int                         src_idle_pct   = 0;
    int                         stall_pct      = 0;
    int                         air_level      = 0;

    oxygen_cell_calibrate_and_mod #(.CAL_SAMPLES(CAL_COUNT)) u_dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [DEPTH_W-1:0] mod_depth(logic [CFG_W-1:0] limit, int o2);
        int q;
        q = (MOD_SCALE * int'(limit)) / o2;
        if (q < DEPTH_OFFSET)
            return '0;
        q = q - DEPTH_OFFSET;
        if (q > DEPTH_MAX)
            q = DEPTH_MAX;
        return q[DEPTH_W-1:0];
    endfunction

    // advance the calibration state and work out the reading for one word
    function automatic reading_t predict_reading(logic op, logic signed [SAMPLE_W-1:0] s);
        reading_t r;
        longint   q;
        int       o2;
        r = '0;
        if (op == OP_CAL)
        begin
            cal_sum = cal_sum + s;
            cal_taken++;
            if (cal_taken >= CAL_COUNT)
            begin
                ref_sum   = cal_sum;
                ref_ok    = (ref_sum > 0);
                cal_sum   = '0;
                cal_taken = 0;
                r.cal_done = 1'b1;
            end
            r.no_ref = !ref_ok;
            return r;
        end
        if (!ref_ok)
        begin
            o2 = O2_MAX;
            r.no_ref = 1'b1;
        end
        else if (s <= 0)
            o2 = O2_MIN;
        else
        begin
            q = longint'(air_cfg) * longint'(s) * CAL_COUNT / longint'(ref_sum);
            if (q < O2_MIN)
                q = O2_MIN;
            if (q > O2_MAX)
                q = O2_MAX;
            o2 = int'(q);
        end
        r.o2           = o2[O2_W-1:0];
        r.depth_normal = mod_depth(lim_normal_cfg, o2);
        r.depth_tech   = mod_depth(lim_tech_cfg, o2);
        return r;
    endfunction

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result word with no reading pending");
                err_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (o2_tenths !== want.o2)
                begin
                    $error("o2_tenths: expected %0d, got %0d", want.o2, o2_tenths);
                    err_count++;
                end
                if (depth_normal_tenths !== want.depth_normal)
                begin
                    $error("depth_normal_tenths: expected %0d, got %0d",
                           want.depth_normal, depth_normal_tenths);
                    err_count++;
                end
                if (depth_tech_tenths !== want.depth_tech)
                begin
                    $error("depth_tech_tenths: expected %0d, got %0d",
                           want.depth_tech, depth_tech_tenths);
                    err_count++;
                end
                if (calibration_done !== want.cal_done)
                begin
                    $error("calibration_done: expected %0d, got %0d",
                           want.cal_done, calibration_done);
                    err_count++;
                end
                if (not_calibrated !== want.no_ref)
                begin
                    $error("not_calibrated: expected %0d, got %0d",
                           want.no_ref, not_calibrated);
                    err_count++;
                end
            end
        end
    end

    task automatic send_item(input logic op, input int value);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        sample   <= value[SAMPLE_W-1:0];
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(predict_reading(op, value[SAMPLE_W-1:0]));
        words_sent++;
    endtask

    // drop valid, let every reading come back, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_AIR_O2:       air_cfg        = val;
            REG_LIMIT_NORMAL: lim_normal_cfg = val;
            REG_LIMIT_TECH:   lim_tech_cfg   = val;
            default:          ;
        endcase
    endtask

    task automatic write_config(input logic [CFG_W-1:0] air, input logic [CFG_W-1:0] lim_n,
                                input logic [CFG_W-1:0] lim_t);
        write_reg(REG_AIR_O2, air);
        write_reg(REG_LIMIT_NORMAL, lim_n);
        write_reg(REG_LIMIT_TECH, lim_t);
        cfg_valid <= 1'b0;
    endtask

    // mostly calibration runs in air followed by measurement bursts, some noise
    task automatic run_traffic(input int n);
        int target;
        int pick;
        int hi;
        int v;
        target = words_sent + n;
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 25 || air_level == 0)
            begin
                air_level = $urandom_range(1, 30000);
                repeat (CAL_COUNT)
                begin
                    v = air_level + int'($urandom_range(0, air_level / 4)) - air_level / 8;
                    send_item(OP_CAL, v);
                end
            end
            else if (pick < 75)
            begin
                hi = air_level * 6;
                if (hi > ADC_MAX)
                    hi = ADC_MAX;
                repeat ($urandom_range(2, 10))
                begin
                    if ($urandom_range(9) == 0)
                        v = -int'($urandom_range(0, 32768));
                    else
                        v = int'($urandom_range(0, hi));
                    send_item(OP_MEAS, v);
                end
            end
            else
                send_item(logic'($urandom_range(1)), int'($urandom_range(65535)));
        end
    endtask

    task automatic test_uncalibrated();
        send_item(OP_MEAS, ADC_MAX);
        send_item(OP_MEAS, -32768);
        wait_idle();
    endtask

    task automatic test_calibration();
        repeat (CAL_COUNT) send_item(OP_CAL, 2000);
        wait_idle();
    endtask

    task automatic test_measurement_edges();
        int probes[5] = '{2000, ADC_MAX, 1, 0, -32768};
        foreach (probes[i])
            send_item(OP_MEAS, probes[i]);
        wait_idle();
    endtask

    // a negative calibration sum must drop the reference
    task automatic test_reference_drop();
        repeat (CAL_COUNT) send_item(OP_CAL, -5);
        send_item(OP_MEAS, 2000);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        logic [CFG_W-1:0] airs[4]  = '{8'd150, 8'd250, 8'd0,   8'd255};
        logic [CFG_W-1:0] norms[4] = '{8'd100, 8'd200, 8'd0,   8'd255};
        logic [CFG_W-1:0] techs[4] = '{8'd100, 8'd200, 8'd255, 8'd0};
        foreach (airs[i])
        begin
            write_config(airs[i], norms[i], techs[i]);
            run_traffic(50);
            wait_idle();
        end
    endtask

    task automatic test_idle_modes();
        int src_modes[4]   = '{0, 80, 0, 22};
        int stall_modes[4] = '{0, 0, 80, 22};
        foreach (src_modes[i])
        begin
            src_idle_pct = src_modes[i];
            stall_pct    = stall_modes[i];
            write_config(CFG_W'($urandom_range(150, 250)), CFG_W'($urandom_range(100, 200)),
                         CFG_W'($urandom_range(100, 200)));
            run_traffic(250);
            wait_idle();
        end
        src_idle_pct = 0;
        stall_pct    = 0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_uncalibrated();
        test_calibration();
        test_measurement_edges();
        test_reference_drop();
        test_config_extremes();
        test_idle_modes();
        wait_idle();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
